FILE: rtl/frm_pkg.sv
// ----------------------------------------------------------------------------
// frm_pkg: shared types and constants of the frame running mean block
// Holds the fixed field widths and the configuration register indexes.
// ----------------------------------------------------------------------------
package frm_pkg;

    // Fixed field widths.
    localparam int PIX_BITS     = 8;
    localparam int SEEN_BITS    = 16;
    localparam int DIM_BITS     = 10;
    localparam int CFG_IDX_BITS = 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

endpackage

FILE: rtl/frm_ram.sv
// ----------------------------------------------------------------------------
// frm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module frm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/frm_div.sv
// ----------------------------------------------------------------------------
// frm_div: iterative restoring divider with an 8-bit quotient
// Produces one quotient bit per cycle; the dividend must stay below
// 256 times the divisor so the quotient fits in a pixel.
// ----------------------------------------------------------------------------
module frm_div
    import frm_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [COUNT_BITS+PIX_BITS-1:0] i_dividend,
    input  logic [COUNT_BITS-1:0]          i_divisor,
    output logic                           o_done,
    output logic [PIX_BITS-1:0]            o_quotient
);

    localparam int REM_BITS = COUNT_BITS + PIX_BITS;
    localparam int BIT_BITS = $clog2(PIX_BITS);

    logic                r_busy;
    logic                r_done;
    logic [BIT_BITS-1:0] r_bit;
    logic [REM_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic [PIX_BITS-1:0] r_q;

    logic [REM_BITS-1:0] shifted;
    logic [REM_BITS-1:0] diff;
    logic                fits;

    // Trial subtraction of the divisor shifted to the current quotient bit.
    always_comb begin
        shifted = {{PIX_BITS{1'b0}}, r_div} << r_bit;
        fits    = (r_rem >= shifted);
        diff    = r_rem - shifted;
    end

    // Control: busy while the quotient bits are produced, done pulses after the last.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_bit == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_bit == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: remainder, divisor and quotient bits.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_div <= i_divisor;
            r_bit <= BIT_BITS'(PIX_BITS - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= diff;
            end
            r_q[r_bit] <= fits;
            r_bit      <= r_bit - 1'b1;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/frame_running_mean.sv
// ----------------------------------------------------------------------------
// frame_running_mean: running per-pixel mean over a stream of frames
// Data path: in the first frame a pixel goes straight to write-back; in later
// frames it passes read, multiply-add, 8-step divider and write-back.
// Flow: a new pixel is taken only after the last one has been written back,
// set by the bit-serial divider and the single read-modify-write.
// Reset clears the position, the frame count, the size registers (500x500)
// and the handshake; the mean store is not cleared and is valid once written.
// ----------------------------------------------------------------------------
module frame_running_mean
    import frm_pkg::*;
#(
    parameter int MAX_PIXELS = 262144,
    parameter int COUNT_BITS = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // Configuration write channel.
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [DIM_BITS-1:0]     i_cfg_data,
    // Pixel input stream.
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    input  logic [7:0]              i_s_tdata,   // [7:0] pixel_in
    // Mean output stream.
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    output logic [23:0]             o_m_tdata,   // [7:0] mean_pixel, [23:8] frames_seen
    output logic                    o_m_tlast    // frame_last
);

    localparam int POS_BITS  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int SIZE_BITS = $clog2(MAX_PIXELS + 1);
    localparam int PROD_BITS = 2 * DIM_BITS;
    localparam int CMP_BITS  = (PROD_BITS >= SIZE_BITS) ? PROD_BITS : SIZE_BITS;
    localparam int REM_BITS  = COUNT_BITS + PIX_BITS;
    localparam int EXT_BITS  = COUNT_BITS + SEEN_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state                r_state;
    logic [DIM_BITS-1:0]   r_width;
    logic [DIM_BITS-1:0]   r_height;
    logic [POS_BITS-1:0]   r_pos;
    logic [COUNT_BITS-1:0] r_count;
    logic [POS_BITS-1:0]   r_addr;
    logic [PIX_BITS-1:0]   r_pix;
    logic                  r_last;
    logic [PIX_BITS-1:0]   r_mean;
    logic                  r_m_valid;
    logic [23:0]           r_m_data;
    logic                  r_m_last;

    logic                  s_accept;
    logic                  out_free;
    logic [DIM_BITS-1:0]   w_eff;
    logic [DIM_BITS-1:0]   h_eff;
    logic [CMP_BITS-1:0]   prod;
    logic [SIZE_BITS-1:0]  size;
    logic                  last;
    logic [COUNT_BITS-1:0] n_count;
    logic [PIX_BITS-1:0]   rd_data;
    logic [REM_BITS-1:0]   dividend;
    logic                  div_start;
    logic                  div_done;
    logic [PIX_BITS-1:0]   div_q;
    logic [EXT_BITS-1:0]   count_ext;
    logic [SEEN_BITS-1:0]  seen;
    logic                  mem_we;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_m_valid || i_m_tready;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= DIM_BITS'(500);
            r_height <= DIM_BITS'(500);
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data;
            endcase
        end
    end

    // Frame size: zero dimensions count as one, the product saturates at the store size.
    always_comb begin
        w_eff = (r_width == '0) ? DIM_BITS'(1) : r_width;
        h_eff = (r_height == '0) ? DIM_BITS'(1) : r_height;
        prod  = CMP_BITS'(w_eff) * CMP_BITS'(h_eff);
        size  = (prod > CMP_BITS'(MAX_PIXELS)) ? SIZE_BITS'(MAX_PIXELS) : SIZE_BITS'(prod);
        last  = ((SIZE_BITS'(r_pos) + 1'b1) >= size);
    end

    // Frame count after this pixel: bumps at the frame start, saturating.
    assign n_count = ((r_pos == '0) && (r_count != '1)) ? r_count + 1'b1 : r_count;

    // Mean store: read at request, written back when the result leaves.
    assign mem_we = (r_state == S_OUT) && out_free;

    frm_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_PIXELS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (r_mean),
        .i_re    (s_accept),
        .i_raddr (r_pos),
        .o_rdata (rd_data)
    );

    // Weighted sum old*(n-1)+new feeds the divider.
    assign dividend = REM_BITS'({{COUNT_BITS{1'b0}}, rd_data} * {{PIX_BITS{1'b0}}, r_count - 1'b1})
                    + REM_BITS'(r_pix);
    assign div_start = (r_state == S_MUL);

    frm_div #(
        .COUNT_BITS (COUNT_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_count),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Frame count as shown on the output, saturated to its field.
    always_comb begin
        count_ext = EXT_BITS'(r_count);
        seen      = (count_ext > EXT_BITS'({SEEN_BITS{1'b1}})) ? '1 : SEEN_BITS'(r_count);
    end

    // Sequencer, position and count state, and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos     <= '0;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_accept) begin
                        r_count <= n_count;
                        r_pos   <= last ? '0 : r_pos + 1'b1;
                        r_state <= (n_count == COUNT_BITS'(1)) ? S_OUT : S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // Payload registers for the request in progress.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_addr <= r_pos;
            r_pix  <= i_s_tdata[PIX_BITS-1:0];
            r_last <= last;
            r_mean <= i_s_tdata[PIX_BITS-1:0];
        end else if ((r_state == S_DIV) && div_done) begin
            r_mean <= div_q;
        end
        if (mem_we) begin
            r_m_data <= {seen, r_mean};
            r_m_last <= r_last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tlast  = r_m_last;

endmodule
